FILE: rtl/mss_pkg.sv
package mss_pkg;
    localparam int LEAVES_DEF = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int SUM_BITS = 48;
    localparam int COUNT_BITS = 11;
    localparam int POS_BITS = 10;
    localparam int BEST_BITS = 47;
    localparam logic [0:0] REQ_UPDATE = 1'b0;
    localparam logic [0:0] REQ_QUERY = 1'b1;
    localparam logic signed [SUM_BITS-1:0] SUM_LIMIT = 48'sh7FFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic signed [SUM_BITS-1:0] prefix;
        logic signed [SUM_BITS-1:0] suffix;
        logic signed [SUM_BITS-1:0] best;
    } t_rec;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LEAF, OP_RD_PAIR, OP_STORE,
        OP_Q_RD, OP_Q_JOIN, OP_Q_STEP, OP_DONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic up_last;
        logic q_empty;
        logic q_hi;
    } t_stat;

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] a, input logic signed [SUM_BITS-1:0] b);
        logic signed [SUM_BITS:0] s;
        logic signed [SUM_BITS:0] lim;
        lim = {1'b0, SUM_LIMIT};
        s = $signed({a[SUM_BITS-1], a}) + $signed({b[SUM_BITS-1], b});
        if (s > lim) return SUM_LIMIT;
        if (s < -lim) return -SUM_LIMIT;
        return s[SUM_BITS-1:0];
    endfunction

    function automatic logic signed [SUM_BITS-1:0] max2(
        input logic signed [SUM_BITS-1:0] a, input logic signed [SUM_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_rec join_rec(input t_rec a, input t_rec b);
        t_rec r;
        r.sum = sat_add(a.sum, b.sum);
        r.prefix = max2(a.prefix, sat_add(a.sum, b.prefix));
        r.suffix = max2(b.suffix, sat_add(b.sum, a.suffix));
        r.best = max2(max2(a.best, b.best), sat_add(a.suffix, b.prefix));
        return r;
    endfunction
endpackage

FILE: rtl/max_subarray_segment_tree_top.sv
// max subarray segment tree
// start/busy command channel: a transaction is taken when start is high and busy low
// update (req_type 0) writes one element and rewalks its ancestors, then runs a
// whole-array query; query (req_type 1) returns the best sum over [start, end)
// result is valid on o_best_sum while o_done is high for one cycle, in the first cycle
// after busy falls; the receiver cannot stall, so nothing ever waits on it
// busy time: an update rewalks each ancestor level, then queries level by level;
// an empty range skips the level walk; set by the single-port node memory
// a new transaction may be taken in the cycle that carries o_done; one at a time
// i_cfg_valid/o_cfg_ready write elem_count; taken whenever the block is idle
// after reset the whole node memory is cleared, one entry a cycle,
// busy is held high during that pass
module max_subarray_segment_tree_top #(
    parameter int LEAVES = mss_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = mss_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [0:0]                         i_req_type,
    input  logic [mss_pkg::POS_BITS-1:0]       i_position,
    input  logic signed [VALUE_BITS-1:0]       i_new_value,
    input  logic [mss_pkg::COUNT_BITS-1:0]     i_range_start,
    input  logic [mss_pkg::COUNT_BITS-1:0]     i_range_end,
    output logic                               o_done,
    output logic [mss_pkg::BEST_BITS-1:0]      o_best_sum,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mss_pkg::COUNT_BITS-1:0]     i_cfg_data
);
    import mss_pkg::*;
    localparam int CW = $clog2(LEAVES) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LEAF, S_RD0, S_RD1, S_RD2, S_STORE,
        S_QCHK, S_QRD, S_QJOIN, S_QSTEP, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic r_req, r_done, n_done;
    logic [POS_BITS-1:0] r_pos;
    logic signed [VALUE_BITS-1:0] r_val;
    logic [COUNT_BITS-1:0] r_rs, r_re;
    t_cmd cmd;
    t_stat stat;
    logic [COUNT_BITS:0] cfg_v;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done = r_done;
    assign cfg_v = {1'b0, i_cfg_data};

    always_comb begin
        n_state = r_state;
        n_done = 1'b0;
        cmd.op = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: if (start) n_state = S_LEAF;
            S_LEAF: begin
                cmd.op = OP_LEAF;
                n_state = S_RD0;
            end
            S_RD0: n_state = stat.up_last ? S_QCHK : S_RD1;
            S_RD1: begin
                cmd.op = OP_RD_PAIR;
                n_state = S_RD2;
            end
            S_RD2: begin
                cmd.op = OP_RD_PAIR;
                n_state = S_STORE;
            end
            S_STORE: begin
                cmd.op = OP_STORE;
                n_state = S_RD0;
            end
            S_QCHK: n_state = stat.q_empty ? S_FIN : S_QRD;
            S_QRD: begin
                cmd.op = OP_Q_RD;
                n_state = S_QJOIN;
            end
            S_QJOIN: begin
                cmd.op = OP_Q_JOIN;
                n_state = stat.q_hi ? S_QSTEP : S_QRD;
            end
            S_QSTEP: begin
                cmd.op = OP_Q_STEP;
                n_state = S_QCHK;
            end
            S_FIN: begin
                cmd.op = OP_DONE;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= CW'(LEAVES);
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                if (cfg_v == '0) r_count <= CW'(1);
                else if (cfg_v > (COUNT_BITS+1)'(LEAVES)) r_count <= CW'(LEAVES);
                else r_count <= CW'(cfg_v);
            end
            if (start && !busy) begin
                r_req <= i_req_type;
                r_pos <= i_position;
                r_val <= i_new_value;
                r_rs <= i_range_start;
                r_re <= i_range_end;
            end
        end
    end

    mss_datapath #(.LEAVES(LEAVES), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_count(r_count),
        .i_req_type(r_req),
        .i_position(r_pos),
        .i_new_value(r_val),
        .i_range_start(r_rs),
        .i_range_end(r_re),
        .o_stat(stat),
        .o_best_sum(o_best_sum)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("cfg while busy");
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0) else $error("zero count");
`endif
endmodule

FILE: rtl/mss_datapath.sv
module mss_datapath #(
    parameter int LEAVES = mss_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = mss_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mss_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(LEAVES):0]             i_count,
    input  logic [0:0]                          i_req_type,
    input  logic [mss_pkg::POS_BITS-1:0]        i_position,
    input  logic signed [VALUE_BITS-1:0]        i_new_value,
    input  logic [mss_pkg::COUNT_BITS-1:0]      i_range_start,
    input  logic [mss_pkg::COUNT_BITS-1:0]      i_range_end,
    output mss_pkg::t_stat                      o_stat,
    output logic [mss_pkg::BEST_BITS-1:0]       o_best_sum
);
    import mss_pkg::*;
    localparam int AW = $clog2(LEAVES) + 1;
    localparam int DEPTH = 2 * LEAVES;

    t_rec mem [DEPTH];
    t_rec r_rd;
    t_rec r_acc, r_left, r_right;
    logic [AW-1:0] r_k, r_clr;
    logic [AW:0] r_lo, r_hi;
    logic r_side;
    logic [BEST_BITS-1:0] r_best;
    logic [AW-1:0] rd_addr;
    logic [AW:0] ext_pos, ext_hi, ext_count;
    t_rec leaf, zero_rec, joined, fin_rec;
    logic we;
    logic leaf_we;
    logic [AW-1:0] wa;
    t_rec wd;
    logic signed [SUM_BITS-1:0] v;

    assign zero_rec = '0;
    assign v = SUM_BITS'(i_new_value);
    always_comb begin
        leaf.sum = v;
        leaf.prefix = (v > 0) ? v : '0;
        leaf.suffix = leaf.prefix;
        leaf.best = leaf.prefix;
    end
    assign ext_count = {1'b0, i_count};
    assign ext_pos = (AW+1)'(i_position);
    assign ext_hi = ((AW+1)'(i_range_end) > ext_count) ? ext_count
                                                       : (AW+1)'(i_range_end);
    assign leaf_we = (i_req_type == REQ_UPDATE) && (ext_pos < ext_count);

    // read addressing: update pairs read left child then right child; queries read lo then hi-1
    always_comb begin
        rd_addr = {r_k[AW-2:0], r_side};
        if (i_cmd.op == OP_Q_RD) begin
            rd_addr = r_side ? AW'(r_hi - (AW+1)'(1)) : AW'(r_lo);
        end
    end

    assign joined = join_rec(r_acc, r_rd);
    assign fin_rec = join_rec(r_left, r_right);

    always_comb begin
        we = 1'b0;
        wa = r_k;
        wd = zero_rec;
        case (i_cmd.op)
            OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
                wd = zero_rec;
            end
            OP_LEAF: begin
                we = leaf_we;
                wa = AW'(ext_pos + ext_count);
                wd = leaf;
            end
            OP_STORE: begin
                we = 1'b1;
                wa = r_k;
                wd = joined;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.op == OP_CLEAR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LEAF: begin
                if (leaf_we) r_k <= AW'((ext_pos + ext_count) >> 1);
                else r_k <= '0;
                r_side <= 1'b0;
                if (i_req_type == REQ_UPDATE) begin
                    r_lo <= ext_count;
                    r_hi <= {i_count, 1'b0};
                end else begin
                    r_lo <= (AW+1)'(i_range_start) + ext_count;
                    r_hi <= ext_hi + ext_count;
                end
                r_left <= zero_rec;
                r_right <= zero_rec;
            end
            OP_RD_PAIR: begin
                if (!r_side) begin
                    r_acc <= r_rd;
                end
                r_side <= ~r_side;
            end
            OP_STORE: begin
                r_k <= r_k >> 1;
                r_side <= 1'b0;
            end
            OP_Q_JOIN: begin
                if (!r_side) begin
                    if (r_lo[0]) begin
                        r_left <= join_rec(r_left, r_rd);
                        r_lo <= r_lo + (AW+1)'(1);
                    end
                end else begin
                    if (r_hi[0]) begin
                        r_right <= join_rec(r_rd, r_right);
                        r_hi <= r_hi - (AW+1)'(1);
                    end
                end
                r_side <= ~r_side;
            end
            OP_Q_STEP: begin
                r_lo <= r_lo >> 1;
                r_hi <= r_hi >> 1;
                r_side <= 1'b0;
            end
            OP_DONE: r_best <= (fin_rec.best < 0) ? '0 : fin_rec.best[BEST_BITS-1:0];
            default: ;
        endcase
    end

    assign o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_stat.up_last = (r_k == '0);
    assign o_stat.q_empty = !(r_lo < r_hi);
    assign o_stat.q_hi = r_side;
    assign o_best_sum = r_best;
endmodule
